// ===== design/modbus_read_response_checker_assert.svh =====
// Assertion macros for the Modbus read response checker.
`ifndef MODBUS_READ_RESPONSE_CHECKER_ASSERT_SVH
`define MODBUS_READ_RESPONSE_CHECKER_ASSERT_SVH
`ifndef SYNTHESIS
`define MBRC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MBRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MBRC_ASSERT(label, prop, msg)
`define MBRC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== design/mbrc_pkg.sv =====
// Shared types and constants for the Modbus read response checker.
package mbrc_pkg;

  localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;
  localparam logic [8:0]  POS_MAX           = 9'd511;

  localparam logic [7:0] SLAVE_RESET = 8'd1;
  localparam logic [6:0] REGS_RESET  = 7'd2;

  // Register indexes on the configuration port.
  localparam logic REG_SLAVE = 1'b0;
  localparam logic REG_REGS  = 1'b1;

  // One byte request handed from the input register to the frame checker.
  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
    logic       end_of_frame;
  } step_t;

endpackage

// ===== design/mbrc_crc16_byte.sv =====
// Byte-wide unrolled CRC-16 update with the reflected polynomial.
module mbrc_crc16_byte (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data_in};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ mbrc_pkg::CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

// ===== design/mbrc_frame_check.sv =====
// Per-frame state and checks: header, byte count, CRC and length.
module mbrc_frame_check (
  input  logic           clk,
  input  logic           rst_n,
  input  mbrc_pkg::step_t step,
  input  logic [7:0]     slave,
  input  logic [6:0]     regs,
  output logic           frame_ok
);

  logic [8:0]  pos_r, pos_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        hdr_bad_r, hdr_bad_nxt;
  logic [7:0]  dlen_r, dlen_nxt;
  logic [7:0]  crc_low_r, crc_low_nxt;
  logic        crc_mis_r, crc_mis_nxt;

  logic [15:0] crc_upd;
  logic [9:0]  crc_end;
  logic [9:0]  pos_ext;

  mbrc_crc16_byte u_crc (
    .crc_in  (crc_r),
    .data_in (step.rx_byte),
    .crc_out (crc_upd)
  );

  always_comb begin
    hdr_bad_nxt = hdr_bad_r;
    dlen_nxt    = dlen_r;
    crc_nxt     = crc_r;
    crc_low_nxt = crc_low_r;
    crc_mis_nxt = crc_mis_r;

    if (pos_r == 9'd0 && step.rx_byte != slave) begin
      hdr_bad_nxt = 1'b1;
    end
    if (pos_r == 9'd1 && step.rx_byte != mbrc_pkg::FUNC_READ_HOLDING) begin
      hdr_bad_nxt = 1'b1;
    end
    if (pos_r == 9'd2) begin
      dlen_nxt = step.rx_byte;
      if (step.rx_byte != {regs, 1'b0}) begin
        hdr_bad_nxt = 1'b1;
      end
    end

    // The covered span ends right after the data; the CRC pair follows it.
    crc_end = {2'b00, dlen_nxt} + 10'd3;
    pos_ext = {1'b0, pos_r};
    if (pos_ext < crc_end) begin
      crc_nxt = crc_upd;
    end else if (pos_ext == crc_end) begin
      crc_low_nxt = step.rx_byte;
    end else if (pos_ext == crc_end + 10'd1) begin
      if ({step.rx_byte, crc_low_r} != crc_r) begin
        crc_mis_nxt = 1'b1;
      end
    end

    pos_nxt = (pos_r == mbrc_pkg::POS_MAX) ? pos_r : pos_r + 9'd1;

    frame_ok = !hdr_bad_nxt && !crc_mis_nxt &&
               ({1'b0, pos_nxt} >= {2'b00, dlen_nxt} + 10'd5);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      crc_r     <= mbrc_pkg::CRC_INIT;
      hdr_bad_r <= 1'b0;
      dlen_r    <= '0;
      crc_low_r <= '0;
      crc_mis_r <= 1'b0;
    end else if (step.valid) begin
      if (step.end_of_frame) begin
        pos_r     <= '0;
        crc_r     <= mbrc_pkg::CRC_INIT;
        hdr_bad_r <= 1'b0;
        dlen_r    <= '0;
        crc_low_r <= '0;
        crc_mis_r <= 1'b0;
      end else begin
        pos_r     <= pos_nxt;
        crc_r     <= crc_nxt;
        hdr_bad_r <= hdr_bad_nxt;
        dlen_r    <= dlen_nxt;
        crc_low_r <= crc_low_nxt;
        crc_mis_r <= crc_mis_nxt;
      end
    end
  end

endmodule

// ===== design/modbus_read_response_checker.sv =====
// Top level of the Modbus RTU read-holding-registers response checker.
// A byte request is registered in the input stage and checked by the frame checker as it
// moves on; the pass/fail result of a frame is registered in the result stage behind out_valid.
// Throughput: one byte per cycle, set by the byte-wide unrolled CRC update, while no closing byte is held back.
// Reset (rst_n, synchronous, active low) clears the pipeline, the frame state and
// loads slave address 1 and a register count of 2.
`include "modbus_read_response_checker_assert.svh"

module modbus_read_response_checker (
  input  logic        clk,
  input  logic        rst_n,
  // Byte requests.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_end_of_frame,
  // Frame results.
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_frame_ok,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers.
  logic [7:0] slave_r;
  logic [6:0] regs_r;

  // Input register stage.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_eof_r;
  logic       s1_adv;

  // Result register stage.
  logic       out_valid_r;
  logic       out_ok_r;

  mbrc_pkg::step_t step;
  logic            frame_ok;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Reads are combinational on the address; the unused upper bits read as zero.
  always_comb begin
    case (paddr[2])
      mbrc_pkg::REG_SLAVE: prdata = {24'd0, slave_r};
      mbrc_pkg::REG_REGS:  prdata = {25'd0, regs_r};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_r <= mbrc_pkg::SLAVE_RESET;
      regs_r  <= mbrc_pkg::REGS_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        mbrc_pkg::REG_SLAVE: slave_r <= pwdata[7:0];
        mbrc_pkg::REG_REGS:  regs_r  <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // A byte that does not close a frame never needs the result register, so it
  // always moves on. A closing byte waits only while an older result is still
  // held and not being taken this cycle.
  assign s1_adv   = s1_valid_r && (!s1_eof_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_rx_byte;
      s1_eof_r  <= in_end_of_frame;
    end
  end

  assign step.valid        = s1_adv;
  assign step.rx_byte      = s1_byte_r;
  assign step.end_of_frame = s1_eof_r;

  mbrc_frame_check u_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .slave    (slave_r),
    .regs     (regs_r),
    .frame_ok (frame_ok)
  );

  // The result register loads on the closing byte of a frame and drops once
  // the result has been taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_eof_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_eof_r) begin
      out_ok_r <= frame_ok;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_frame_ok = out_ok_r;

  // The input side only stalls behind a byte that is waiting in the input register.
  `MBRC_ASSERT(a_stall_has_byte, (!in_ready |-> s1_valid_r), "in_ready low with empty input stage")
  // A fresh result always comes from a closing byte that moved on in the previous cycle.
  `MBRC_ASSERT_NEXT(a_result_source, (!out_valid_r && !(s1_adv && s1_eof_r)), !out_valid_r, "result appeared without a closing byte")
  // A write to the slave address register shows up in the following cycle.
  `MBRC_ASSERT_NEXT(a_cfg_slave, (cfg_wr && paddr[2] == mbrc_pkg::REG_SLAVE), (slave_r == $past(pwdata[7:0])), "slave address write lost")

endmodule

// ===== tb/frame_verdict_checker.sv =====
// Checker that predicts and compares the pass/fail verdict of each response frame.
module frame_verdict_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_end_of_frame,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_frame_ok,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          error_count,
  output int          verdicts_pending
);

  logic [7:0]  slave_setting;
  logic [6:0]  regs_setting;

  logic [8:0]  pos_count;
  logic [15:0] crc_acc;
  logic        header_fail;
  logic [7:0]  byte_count_field;
  logic [7:0]  crc_low_byte;
  logic        crc_fail;

  logic        expected_verdicts[$];

  initial error_count = 0;

  task automatic note_error(input string msg);
    if (error_count < 10) $display("%s", msg);
    error_count++;
  endtask

  always @(posedge clk) begin : track
    int   p;
    logic verdict;
    logic want;
    if (!rst_n) begin
      slave_setting = mbrc_pkg::SLAVE_RESET;
      regs_setting = mbrc_pkg::REGS_RESET;
      pos_count = '0;
      crc_acc = mbrc_pkg::CRC_INIT;
      header_fail = 1'b0;
      byte_count_field = '0;
      crc_low_byte = '0;
      crc_fail = 1'b0;
      expected_verdicts.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          mbrc_pkg::REG_SLAVE: slave_setting = pwdata[7:0];
          mbrc_pkg::REG_REGS:  regs_setting = pwdata[6:0];
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        p = pos_count;
        if (p == 0) begin
          if (in_rx_byte != slave_setting) header_fail = 1'b1;
        end else if (p == 1) begin
          if (in_rx_byte != mbrc_pkg::FUNC_READ_HOLDING) header_fail = 1'b1;
        end else if (p == 2) begin
          byte_count_field = in_rx_byte;
          if (in_rx_byte != {regs_setting, 1'b0}) header_fail = 1'b1;
        end

        // The header and data bytes feed the CRC, the next two carry it.
        if (p < 3 + byte_count_field) begin
          crc_acc = crc_acc ^ {8'h00, in_rx_byte};
          repeat (8) crc_acc = crc_acc[0] ? ((crc_acc >> 1) ^ mbrc_pkg::CRC_POLY)
                                          : (crc_acc >> 1);
        end else if (p == 3 + byte_count_field) begin
          crc_low_byte = in_rx_byte;
        end else if (p == 4 + byte_count_field) begin
          if ({in_rx_byte, crc_low_byte} != crc_acc) crc_fail = 1'b1;
        end

        pos_count = (p < mbrc_pkg::POS_MAX) ? p + 1 : mbrc_pkg::POS_MAX;

        if (in_end_of_frame) begin
          verdict = !header_fail && !crc_fail && (pos_count >= 5 + byte_count_field);
          expected_verdicts.push_back(verdict);
          pos_count = '0;
          crc_acc = mbrc_pkg::CRC_INIT;
          header_fail = 1'b0;
          byte_count_field = '0;
          crc_low_byte = '0;
          crc_fail = 1'b0;
        end
      end

      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          note_error($sformatf("Unexpected result: frame_ok %0b with no frame pending",
                               out_frame_ok));
        end else begin
          want = expected_verdicts.pop_front();
          if (out_frame_ok !== want)
            note_error($sformatf("frame_ok mismatch: expected %0b, got %0b",
                                 want, out_frame_ok));
        end
      end
    end
    verdicts_pending <= expected_verdicts.size();
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the testbench: clock, reset, stimulus for the response checker, and the verdict.
module testbench;

  // Settling time after the last verdict has been taken; it covers bytes
  // still inside the pipeline that make no verdict.
  localparam int SETTLE_CYCLES = 4;
  // Length of the receiver hold-off that backs the block up into its input.
  localparam int STALL_CYCLES  = 400;
  // Least number of byte requests sent in each random phase; a phase ends on a frame boundary.
  localparam int PHASE_BYTES   = 45;
  // Hard stop, far above the slowest correct run.
  localparam int LIMIT_CYCLES  = 200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = '0;
  logic        in_end_of_frame = 1'b0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_frame_ok;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int          error_count;
  int          verdicts_pending;

  // Idle rates in percent for the sender and the receiver.
  int          send_idle_pct = 7;
  int          recv_idle_pct = 51;
  logic        stall_arm = 1'b0;
  logic        out_stall = 1'b0;

  // Settings the stimulus builds frames against; they follow every write.
  logic [7:0]  cur_slave = mbrc_pkg::SLAVE_RESET;
  logic [6:0]  cur_regs = mbrc_pkg::REGS_RESET;

  logic [7:0]  frame_bytes[$];
  int          bytes_sent = 0;

  always #5 clk = ~clk;

  modbus_read_response_checker u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .in_end_of_frame (in_end_of_frame),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_frame_ok    (out_frame_ok),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  frame_verdict_checker u_verdict_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .in_end_of_frame  (in_end_of_frame),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_ok     (out_frame_ok),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .error_count      (error_count),
    .verdicts_pending (verdicts_pending)
  );

  // The receiver drops ready at random, and holds it low throughout the long
  // hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !out_stall && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // The long hold-off counts its own cycles once the stimulus arms it, so the
  // sender can keep pushing requests until the block stops taking them.
  initial begin
    wait (stall_arm);
    @(posedge clk);
    out_stall <= 1'b1;
    repeat (STALL_CYCLES) @(posedge clk);
    out_stall <= 1'b0;
  end

  // One APB write: a setup phase, then an access phase that completes on pready.
  task automatic cfg_write(input logic idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == mbrc_pkg::REG_SLAVE) cur_slave = value[7:0];
    else cur_regs = value[6:0];
  endtask

  // Offers one byte request and returns at the edge that accepts it. Valid is
  // left high so the next request can follow without a bubble; an idle gap
  // lowers it first, never in the same step it is raised again.
  task automatic send_byte(input logic [7:0] b, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    in_end_of_frame <= last;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // Builds a complete response with random register data and a correct
  // CRC-16 over the header and data, low byte first.
  task automatic make_response(input logic [7:0] slave, input logic [7:0] func,
                               input logic [7:0] count);
    logic [15:0] crc;
    frame_bytes = {slave, func, count};
    repeat (count) frame_bytes.push_back(8'($urandom_range(255)));
    crc = mbrc_pkg::CRC_INIT;
    foreach (frame_bytes[i]) begin
      crc = crc ^ {8'h00, frame_bytes[i]};
      repeat (8) crc = crc[0] ? ((crc >> 1) ^ mbrc_pkg::CRC_POLY) : (crc >> 1);
    end
    frame_bytes.push_back(crc[7:0]);
    frame_bytes.push_back(crc[15:8]);
  endtask

  // One random frame. Fewer than half are well formed so the CRC and length logic gets
  // exercised; the rest carry a wrong header field, a corrupted bit, a cut,
  // trailing bytes, or are plain noise.
  task automatic random_frame();
    int          pick;
    int          cut;
    int          pos;
    logic [7:0]  slave;
    logic [7:0]  func;
    logic [7:0]  count;
    pick = $urandom_range(99);
    if (pick < 12) begin
      frame_bytes = {};
      repeat ($urandom_range(1, 8)) frame_bytes.push_back(8'($urandom_range(255)));
    end else begin
      slave = cur_slave;
      func = mbrc_pkg::FUNC_READ_HOLDING;
      count = {cur_regs, 1'b0};
      if (pick < 18) slave = cur_slave ^ 8'($urandom_range(1, 255));
      else if (pick < 24) func = mbrc_pkg::FUNC_READ_HOLDING ^ 8'($urandom_range(1, 255));
      else if (pick < 30) count = count ^ 8'($urandom_range(1, 7));
      make_response(slave, func, count);
      if (pick >= 30 && pick < 40) begin
        pos = $urandom_range(0, frame_bytes.size() - 1);
        frame_bytes[pos] = frame_bytes[pos] ^ (8'h01 << $urandom_range(0, 7));
      end else if (pick >= 40 && pick < 48) begin
        cut = $urandom_range(1, frame_bytes.size() - 1);
        while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
      end else if (pick >= 48 && pick < 58) begin
        repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom_range(255)));
      end
    end
    send_frame();
  endtask

  task automatic random_phase();
    int start;
    start = bytes_sent;
    while (bytes_sent - start < PHASE_BYTES) random_frame();
  endtask

  // Stops offering requests and waits until every verdict has been taken,
  // plus the pipeline depth, so the block is idle for register writes.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames at the reset settings (slave 1, two registers): a lone
    // zero byte, a good response, the same with a broken CRC high byte, a
    // lone all-ones byte, and a frame that stops after its header.
    frame_bytes = {8'h00};
    send_frame();
    make_response(mbrc_pkg::SLAVE_RESET, mbrc_pkg::FUNC_READ_HOLDING,
                  {mbrc_pkg::REGS_RESET, 1'b0});
    send_frame();
    make_response(mbrc_pkg::SLAVE_RESET, mbrc_pkg::FUNC_READ_HOLDING,
                  {mbrc_pkg::REGS_RESET, 1'b0});
    frame_bytes[frame_bytes.size() - 1] = ~frame_bytes[frame_bytes.size() - 1];
    send_frame();
    frame_bytes = {8'hFF};
    send_frame();
    frame_bytes = {mbrc_pkg::SLAVE_RESET, mbrc_pkg::FUNC_READ_HOLDING,
                   {mbrc_pkg::REGS_RESET, 1'b0}};
    send_frame();

    // Sender mostly busy, receiver idling about half the time; address zero
    // and one register.
    wait_idle();
    cfg_write(mbrc_pkg::REG_SLAVE, 32'd0);
    cfg_write(mbrc_pkg::REG_REGS, 32'd1);
    random_phase();

    // Roles swapped; the highest address and no registers at all, so a good
    // response is just header and CRC.
    wait_idle();
    send_idle_pct <= 51;
    recv_idle_pct <= 7;
    cfg_write(mbrc_pkg::REG_SLAVE, 32'd255);
    cfg_write(mbrc_pkg::REG_REGS, 32'd0);
    random_phase();

    // No idling. Single-byte frames each make a verdict, so while the
    // receiver holds off the result side backs up and the block must stall
    // its input.
    wait_idle();
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    cfg_write(mbrc_pkg::REG_SLAVE, 32'($urandom_range(255)));
    cfg_write(mbrc_pkg::REG_REGS, 32'($urandom_range(1, 4)));
    stall_arm = 1'b1;
    repeat (40) begin
      frame_bytes = {8'($urandom_range(255))};
      send_frame();
    end
    random_phase();

    // The largest register count: one good response padded with trailing
    // bytes well past the point where the position counter saturates, then a
    // response cut short.
    wait_idle();
    cfg_write(mbrc_pkg::REG_SLAVE, 32'($urandom_range(255)));
    cfg_write(mbrc_pkg::REG_REGS, 32'd127);
    make_response(cur_slave, mbrc_pkg::FUNC_READ_HOLDING, {cur_regs, 1'b0});
    while (frame_bytes.size() < 520) frame_bytes.push_back(8'($urandom_range(255)));
    send_frame();
    make_response(cur_slave, mbrc_pkg::FUNC_READ_HOLDING, {cur_regs, 1'b0});
    while (frame_bytes.size() > 40) void'(frame_bytes.pop_back());
    send_frame();

    wait_idle();
    if (error_count == 0 && verdicts_pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * 10);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/mbrc_pkg.sv
design/mbrc_crc16_byte.sv
design/mbrc_frame_check.sv
design/modbus_read_response_checker.sv
tb/frame_verdict_checker.sv
tb/testbench.sv
